// ----- rtl/core/djs_pkg.sv -----
package djs_pkg;

    // fixed field widths
    localparam int ID_W       = 8;
    localparam int PROFIT_W   = 16;
    localparam int DL_W       = 6;
    localparam int SLOT_IDX_W = 5;
    localparam int SUM_W      = 21;

    // saturation ceiling of the running profit
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one job as it arrives, also the queue entry after deadline clamping
    typedef struct packed {
        logic [ID_W-1:0]     job_id;
        logic [PROFIT_W-1:0] job_profit;
        logic [DL_W-1:0]     job_deadline;
        logic                last_job;
    } t_job_item;

    // one stored job in the back job memory
    typedef struct packed {
        logic [ID_W-1:0]     job_id;
        logic [PROFIT_W-1:0] job_profit;
        logic [DL_W-1:0]     job_deadline;
    } t_job_ent;

    // one slot report
    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  slot_used;
        logic [ID_W-1:0]       slot_job;
        logic [SUM_W-1:0]      total_profit;
        logic                  last_slot;
    } t_slot_item;

endpackage

// ----- rtl/core/djs_stream_if.sv -----
interface djs_stream_if #(
    parameter type T_PAYLOAD = logic
) ();

    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/core/deadline_job_sequencer.sv -----
// Greedy deadline job sequencer. Jobs enter one per transaction on i_job and
// are clamped to MAX_SLOTS and queued; a transaction with last_job set closes
// the batch. The batch is then ordered by profit with an in-place exchange sort
// over the job memory with its one write and one read port (one compare per
// cycle), placed into slots at one job per cycle, and reported on o_slot at one
// slot per cycle while o_slot is ready, from slot 0 up to the largest deadline.
// Every report carries the final batch profit, saturated at 21 bits. While a
// batch is in progress the front keeps taking jobs of the next batch until
// its short queue fills. Jobs beyond MAX_JOBS in a batch are dropped, and a
// deadline of zero never gets a slot.
module deadline_job_sequencer #(
    parameter int MAX_JOBS  = 32,
    parameter int MAX_SLOTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    djs_stream_if.sink   i_job,
    djs_stream_if.source o_slot
);

    djs_stream_if #(.T_PAYLOAD(djs_pkg::t_job_item)) front_to_q ();
    djs_stream_if #(.T_PAYLOAD(djs_pkg::t_job_item)) q_to_back ();

    // input register and deadline clamp
    djs_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (i_job),
        .o_job   (front_to_q)
    );

    // job queue between front and back
    djs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_to_q),
        .o_pop   (q_to_back)
    );

    // store, sort, slot assignment and reporting
    djs_back #(
        .MAX_JOBS  (MAX_JOBS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_to_back),
        .o_slot  (o_slot)
    );

endmodule

// ----- rtl/core/djs_front.sv -----
module djs_front #(
    parameter int MAX_SLOTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    djs_stream_if.sink   i_job,
    djs_stream_if.source o_job
);

    localparam int DLX = djs_pkg::DL_W + 1;

    logic                r_valid;
    djs_pkg::t_job_item  r_job;
    djs_pkg::t_job_item  job_cl;
    logic [DLX-1:0]      dl_ext;

    // take a new transaction whenever the holding register is free or drains
    assign i_job.ready = !r_valid || o_job.ready;

    // clamp the deadline to the number of slots
    always_comb begin
        job_cl = i_job.payload;
        dl_ext = {1'b0, i_job.payload.job_deadline};
        if (dl_ext > DLX'(MAX_SLOTS)) begin
            job_cl.job_deadline = djs_pkg::DL_W'(MAX_SLOTS);
        end
    end

    // holding register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_job.ready) begin
            r_valid <= i_job.valid;
        end
    end

    // holding register payload
    always_ff @(posedge i_clk) begin
        if (i_job.valid && i_job.ready) begin
            r_job <= job_cl;
        end
    end

    assign o_job.valid   = r_valid;
    assign o_job.payload = r_job;

endmodule

// ----- rtl/core/djs_fifo.sv -----
module djs_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    djs_stream_if.sink   i_push,
    djs_stream_if.source o_pop
);

    localparam int PW = (djs_pkg::QUEUE_DEPTH > 1) ? $clog2(djs_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(djs_pkg::QUEUE_DEPTH + 1);

    djs_pkg::t_job_item r_store [djs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]      r_wr_ptr;
    logic [PW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_fill;
    logic               push;
    logic               pop;

    assign i_push.ready  = (r_fill != CW'(djs_pkg::QUEUE_DEPTH));
    assign o_pop.valid   = (r_fill != '0);
    assign o_pop.payload = r_store[r_rd_ptr];

    assign push = i_push.valid && i_push.ready;
    assign pop  = o_pop.valid && o_pop.ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(djs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(djs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + CW'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - CW'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_store[r_wr_ptr] <= i_push.payload;
        end
    end

endmodule

// ----- rtl/core/djs_back.sv -----
module djs_back #(
    parameter int MAX_JOBS  = 32,
    parameter int MAX_SLOTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    djs_stream_if.sink   i_job,
    djs_stream_if.source o_slot
);

    localparam int JW  = $clog2(MAX_JOBS);
    localparam int CW  = $clog2(MAX_JOBS + 1);
    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int DW  = djs_pkg::DL_W;
    localparam int DLX = djs_pkg::DL_W + 1;
    localparam int SMW = djs_pkg::SUM_W;

    // sequencer states
    localparam logic [2:0] ST_LOAD      = 3'd0;
    localparam logic [2:0] ST_SORT_LDI  = 3'd1;
    localparam logic [2:0] ST_SORT_CAPI = 3'd2;
    localparam logic [2:0] ST_SORT_CMP  = 3'd3;
    localparam logic [2:0] ST_SORT_WRI  = 3'd4;
    localparam logic [2:0] ST_ASN_RD    = 3'd5;
    localparam logic [2:0] ST_ASN_DO    = 3'd6;
    localparam logic [2:0] ST_EMIT      = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [DW-1:0]           r_maxdl, n_maxdl;
    logic [CW-1:0]           r_i, n_i;
    logic [CW-1:0]           r_j, n_j;
    logic [CW-1:0]           r_k, n_k;
    djs_pkg::t_job_ent       r_cur, n_cur;
    logic [MAX_SLOTS-1:0]    r_taken, n_taken;
    logic [SMW-1:0]          r_sum, n_sum;
    logic [DW-1:0]           r_es, n_es;
    logic                    r_pend, n_pend;
    logic                    r_out_valid, n_out_valid;
    djs_pkg::t_slot_item     r_out, n_out;

    // job memory
    djs_pkg::t_job_ent       mem_job [MAX_JOBS];
    djs_pkg::t_job_ent       r_rdata;
    logic                    mem_we;
    logic [JW-1:0]           mem_waddr;
    djs_pkg::t_job_ent       mem_wdata;
    logic [JW-1:0]           mem_raddr;

    // slot owner memory
    logic [djs_pkg::ID_W-1:0] mem_owner [MAX_SLOTS];
    logic [djs_pkg::ID_W-1:0] r_owner_q;
    logic                     own_we;
    logic [SW-1:0]            own_waddr;
    logic                     own_re;
    logic [SW-1:0]            own_raddr;

    // slot search and profit update
    logic [MAX_SLOTS-1:0]    free_mask;
    logic                    found;
    logic [SW-1:0]           found_idx;
    logic [SMW:0]            sum_ext;
    logic                    out_free;
    logic                    emit_last;
    logic [CW-1:0]           i_nxt;
    logic [CW-1:0]           j_nxt;
    logic [CW-1:0]           k_nxt;
    logic [DW-1:0]           es_nxt;

    assign i_nxt  = r_i + CW'(1);
    assign j_nxt  = r_j + CW'(1);
    assign k_nxt  = r_k + CW'(1);
    assign es_nxt = r_es + DW'(1);

    // latest free slot below the deadline of the job on the read port
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int b = 0; b < MAX_SLOTS; b++) begin
            free_mask[b] = !r_taken[b] && (DLX'(b) < {1'b0, r_rdata.job_deadline});
        end
        for (int b = 0; b < MAX_SLOTS; b++) begin
            if (free_mask[b]) begin
                found     = 1'b1;
                found_idx = SW'(b);
            end
        end
    end

    // saturating profit sum
    assign sum_ext = {1'b0, r_sum} + (SMW + 1)'(r_rdata.job_profit);

    assign out_free  = !r_out_valid || o_slot.ready;
    assign emit_last = ({1'b0, es_nxt} == {1'b0, r_maxdl});

    assign i_job.ready   = (r_state == ST_LOAD);
    assign o_slot.valid  = r_out_valid;
    assign o_slot.payload = r_out;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_maxdl     = r_maxdl;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_cur       = r_cur;
        n_taken     = r_taken;
        n_sum       = r_sum;
        n_es        = r_es;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !o_slot.ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_count[JW-1:0];
        mem_wdata   = r_cur;
        mem_raddr   = r_i[JW-1:0];
        own_we      = 1'b0;
        own_waddr   = found_idx;
        own_re      = 1'b0;
        own_raddr   = r_es[SW-1:0];

        case (r_state)
            // store jobs until the batch closes
            ST_LOAD: begin
                if (i_job.valid) begin
                    if (r_count < CW'(MAX_JOBS)) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[JW-1:0];
                        mem_wdata = '{job_id:       i_job.payload.job_id,
                                      job_profit:   i_job.payload.job_profit,
                                      job_deadline: i_job.payload.job_deadline};
                        n_count   = r_count + CW'(1);
                        if (i_job.payload.job_deadline > r_maxdl) begin
                            n_maxdl = i_job.payload.job_deadline;
                        end
                    end
                    if (i_job.payload.last_job) begin
                        n_i     = '0;
                        n_state = ST_SORT_LDI;
                    end
                end
            end
            // open outer pass i, or move on to slot assignment
            ST_SORT_LDI: begin
                if (i_nxt < r_count) begin
                    mem_raddr = r_i[JW-1:0];
                    n_state   = ST_SORT_CAPI;
                end else begin
                    n_k     = '0;
                    n_taken = '0;
                    n_sum   = '0;
                    n_state = ST_ASN_RD;
                end
            end
            // hold entry i, fetch entry i+1
            ST_SORT_CAPI: begin
                n_cur     = r_rdata;
                n_j       = i_nxt;
                mem_raddr = i_nxt[JW-1:0];
                n_state   = ST_SORT_CMP;
            end
            // exchange with entry j when it has the larger profit
            ST_SORT_CMP: begin
                if (r_cur.job_profit < r_rdata.job_profit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j[JW-1:0];
                    mem_wdata = r_cur;
                    n_cur     = r_rdata;
                end
                if (j_nxt < r_count) begin
                    n_j       = j_nxt;
                    mem_raddr = j_nxt[JW-1:0];
                end else begin
                    n_state = ST_SORT_WRI;
                end
            end
            // write back the winner of pass i
            ST_SORT_WRI: begin
                mem_we    = 1'b1;
                mem_waddr = r_i[JW-1:0];
                mem_wdata = r_cur;
                n_i       = i_nxt;
                n_state   = ST_SORT_LDI;
            end
            // fetch the first job in profit order
            ST_ASN_RD: begin
                mem_raddr = r_k[JW-1:0];
                if (r_k < r_count) begin
                    n_state = ST_ASN_DO;
                end else begin
                    n_es    = '0;
                    n_pend  = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            // place one job per cycle, fetch the next
            ST_ASN_DO: begin
                if (found) begin
                    n_taken[found_idx] = 1'b1;
                    own_we             = 1'b1;
                    own_waddr          = found_idx;
                    n_sum = sum_ext[SMW] ? djs_pkg::SUM_MAX : sum_ext[SMW-1:0];
                end
                n_k       = k_nxt;
                mem_raddr = k_nxt[JW-1:0];
                if (!(k_nxt < r_count)) begin
                    n_es    = '0;
                    n_pend  = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            // one slot report per cycle while o_slot takes them
            ST_EMIT: begin
                if (r_maxdl == '0) begin
                    n_count = '0;
                    n_state = ST_LOAD;
                end else if (!r_pend) begin
                    own_re    = 1'b1;
                    own_raddr = r_es[SW-1:0];
                    n_pend    = 1'b1;
                end else if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.slot_index   = r_es[djs_pkg::SLOT_IDX_W-1:0];
                    n_out.slot_used    = r_taken[r_es[SW-1:0]];
                    n_out.slot_job     = r_taken[r_es[SW-1:0]] ? r_owner_q : '0;
                    n_out.total_profit = r_sum;
                    n_out.last_slot    = emit_last;
                    n_es               = es_nxt;
                    if (emit_last) begin
                        n_pend  = 1'b0;
                        n_count = '0;
                        n_maxdl = '0;
                        n_state = ST_LOAD;
                    end else begin
                        own_re    = 1'b1;
                        own_raddr = es_nxt[SW-1:0];
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_maxdl     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_taken     <= '0;
            r_sum       <= '0;
            r_es        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_maxdl     <= n_maxdl;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_taken     <= n_taken;
            r_sum       <= n_sum;
            r_es        <= n_es;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_out <= n_out;
    end

    // job memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_job[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem_job[mem_raddr];
    end

    // slot owner memory
    always_ff @(posedge i_clk) begin
        if (own_we) begin
            mem_owner[own_waddr] <= r_rdata.job_id;
        end
        if (own_re) begin
            r_owner_q <= mem_owner[own_raddr];
        end
    end

endmodule

// ----- bench/tb.sv -----
module tb;

    localparam int MAX_JOBS     = 32;
    localparam int MAX_SLOTS    = 32;
    localparam int RANDOM_ITEMS = 290;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 1500;
    localparam int CYCLE_LIMIT  = 500000;

    // deadline styles of a random batch
    typedef enum int {
        DL_TIGHT,
        DL_FULL_RANGE,
        DL_ALL_ZERO
    } t_dl_style;

    // profit styles of a random job
    typedef enum int {
        PR_FULL,
        PR_TIES,
        PR_TOP
    } t_pr_style;

    // tracks the open batch and the slot reports it owes
    class slot_board;
        djs_pkg::t_job_ent   batch_jobs[$];
        djs_pkg::t_slot_item slots_due[$];
        int                  mismatches;
        int                  slots_seen;
        int                  batches_done;
        int                  jobs_taken;
        int                  jobs_dropped;

        function int pending();
            return slots_due.size();
        endfunction

        function void note_job(djs_pkg::t_job_item it);
            djs_pkg::t_job_ent ent;
            ent.job_id       = it.job_id;
            ent.job_profit   = it.job_profit;
            ent.job_deadline = (it.job_deadline > MAX_SLOTS) ? djs_pkg::DL_W'(MAX_SLOTS)
                                                             : it.job_deadline;
            jobs_taken++;
            if (batch_jobs.size() < MAX_JOBS) begin
                batch_jobs.push_back(ent);
            end else begin
                jobs_dropped++;
            end
            if (it.last_job) begin
                schedule_batch();
            end
        endfunction

        // exchange sort by profit, then latest free slot per job
        function void schedule_batch();
            djs_pkg::t_job_ent        tmp;
            logic [djs_pkg::ID_W-1:0] owner[MAX_SLOTS];
            bit                       taken[MAX_SLOTS];
            int unsigned              sum;
            int                       top;
            int                       s;
            djs_pkg::t_slot_item      rep;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                owner[i] = '0;
                taken[i] = 1'b0;
            end
            for (int i = 0; i + 1 < batch_jobs.size(); i++) begin
                for (int j = i + 1; j < batch_jobs.size(); j++) begin
                    if (batch_jobs[i].job_profit < batch_jobs[j].job_profit) begin
                        tmp           = batch_jobs[i];
                        batch_jobs[i] = batch_jobs[j];
                        batch_jobs[j] = tmp;
                    end
                end
            end
            sum = 0;
            top = 0;
            foreach (batch_jobs[i]) begin
                if (batch_jobs[i].job_deadline > top) begin
                    top = batch_jobs[i].job_deadline;
                end
            end
            foreach (batch_jobs[i]) begin
                s = batch_jobs[i].job_deadline;
                while (s > 0) begin
                    if (!taken[s-1]) begin
                        taken[s-1] = 1'b1;
                        owner[s-1] = batch_jobs[i].job_id;
                        sum += batch_jobs[i].job_profit;
                        if (sum > djs_pkg::SUM_MAX) begin
                            sum = djs_pkg::SUM_MAX;
                        end
                        break;
                    end
                    s--;
                end
            end
            for (int k = 0; k < top; k++) begin
                rep.slot_index   = djs_pkg::SLOT_IDX_W'(k);
                rep.slot_used    = taken[k];
                rep.slot_job     = taken[k] ? owner[k] : '0;
                rep.total_profit = djs_pkg::SUM_W'(sum);
                rep.last_slot    = (k + 1 == top);
                slots_due.push_back(rep);
            end
            batch_jobs.delete();
            batches_done++;
        endfunction

        function void cmp_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_slot(djs_pkg::t_slot_item got);
            djs_pkg::t_slot_item want;
            slots_seen++;
            if (slots_due.size() == 0) begin
                $display("%0t: unexpected slot report, expected none actual slot %0d job %0d",
                         $time, got.slot_index, got.slot_job);
                mismatches++;
                return;
            end
            want = slots_due.pop_front();
            cmp_field("slot_index", want.slot_index, got.slot_index);
            cmp_field("slot_used", want.slot_used, got.slot_used);
            cmp_field("slot_job", want.slot_job, got.slot_job);
            cmp_field("total_profit", want.total_profit, got.total_profit);
            cmp_field("last_slot", want.last_slot, got.last_slot);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    djs_stream_if #(.T_PAYLOAD(djs_pkg::t_job_item))  job_if ();
    djs_stream_if #(.T_PAYLOAD(djs_pkg::t_slot_item)) slot_if ();

    deadline_job_sequencer #(
        .MAX_JOBS  (MAX_JOBS),
        .MAX_SLOTS (MAX_SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_if),
        .o_slot  (slot_if)
    );

    slot_board board = new();

    int send_idle_pct = 31;
    int recv_idle_pct = 62;
    int run_phase     = 0;
    int cycle_count   = 0;
    int random_sent   = 0;

    // clock
    always #4 i_clk = ~i_clk;

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("cycle limit reached with %0d slot reports outstanding", board.pending());
        $display("Regression FAIL");
        $finish;
    end

    // slot receiver: checks each transaction, idles at random, one long hold-off
    int  hold_left    = 0;
    bit  hold_started = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_if.ready <= 1'b0;
        end else begin
            if (slot_if.valid && slot_if.ready) begin
                board.check_slot(slot_if.payload);
            end
            if (run_phase == 2 && !hold_started) begin
                hold_started = 1'b1;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                slot_if.ready <= 1'b0;
            end else begin
                slot_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // offer one job and wait for its transaction
    task automatic send_job(input logic [djs_pkg::ID_W-1:0] id,
                            input logic [djs_pkg::PROFIT_W-1:0] profit,
                            input logic [djs_pkg::DL_W-1:0] dl, input logic last);
        djs_pkg::t_job_item it;
        it.job_id       = id;
        it.job_profit   = profit;
        it.job_deadline = dl;
        it.last_job     = last;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            job_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        job_if.valid   <= 1'b1;
        job_if.payload <= it;
        do @(posedge i_clk); while (!job_if.ready);
        board.note_job(it);
    endtask

    // one well-formed batch with random content
    task automatic send_batch(input int n_jobs, input t_dl_style dl_style);
        logic [djs_pkg::PROFIT_W-1:0] profit;
        logic [djs_pkg::DL_W-1:0]     dl;
        t_pr_style                    pr_style;
        for (int k = 0; k < n_jobs; k++) begin
            pr_style = t_pr_style'($urandom_range(0, 2));
            case (pr_style)
                PR_FULL: begin
                    profit = djs_pkg::PROFIT_W'($urandom);
                end
                PR_TIES: begin
                    profit = djs_pkg::PROFIT_W'($urandom_range(0, 7));
                end
                default: begin
                    profit = '1;
                end
            endcase
            case (dl_style)
                DL_TIGHT: begin
                    dl = djs_pkg::DL_W'($urandom_range(1, (n_jobs > 1) ? n_jobs - 1 : 1));
                end
                DL_FULL_RANGE: begin
                    dl = djs_pkg::DL_W'($urandom_range(0, 63));
                end
                default: begin
                    dl = '0;
                end
            endcase
            send_job(djs_pkg::ID_W'($urandom), profit, dl, k == n_jobs - 1);
            random_sent++;
        end
    endtask

    // main sequence
    int        n_jobs;
    int        pick;
    t_dl_style dl_style;
    initial begin
        job_if.valid   = 1'b0;
        job_if.payload = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone job with the top id and profit in the first slot
        send_job(8'd255, 16'hFFFF, 6'd1, 1'b1);
        // only a zero deadline, batch gives no reports
        send_job(8'd0, 16'd0, 6'd0, 1'b1);
        // deadlines above the slot count are clamped
        send_job(8'd1, 16'd100, 6'd63, 1'b0);
        send_job(8'd2, 16'd200, 6'd33, 1'b0);
        send_job(8'd3, 16'd300, 6'd32, 1'b1);
        // contention for the slots below deadline 2 with ties, a zero deadline on the richest job
        send_job(8'd10, 16'd10, 6'd2, 1'b0);
        send_job(8'd11, 16'd40, 6'd2, 1'b0);
        send_job(8'd12, 16'd40, 6'd2, 1'b0);
        send_job(8'd13, 16'hFFFF, 6'd0, 1'b0);
        send_job(8'd14, 16'd20, 6'd2, 1'b1);
        // gaps between occupied slots
        send_job(8'd20, 16'd5, 6'd5, 1'b0);
        send_job(8'd21, 16'd0, 6'd1, 1'b1);
        // jobs that lose every slot they could take
        send_job(8'd30, 16'd1, 6'd1, 1'b0);
        send_job(8'd31, 16'd2, 6'd1, 1'b0);
        send_job(8'd32, 16'd3, 6'd1, 1'b0);
        send_job(8'd33, 16'hAAAA, 6'd4, 1'b0);
        send_job(8'd34, 16'h5555, 6'd42, 1'b1);

        // random batches across three idle settings
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
                run_phase     = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (random_sent >= RANDOM_ITEMS / 3) begin
                run_phase     = 1;
                send_idle_pct = 62;
                recv_idle_pct = 31;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                n_jobs = $urandom_range(1, 8);
            end else if (pick < 92) begin
                n_jobs = $urandom_range(9, 20);
            end else begin
                n_jobs = $urandom_range(30, 36);
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                dl_style = DL_ALL_ZERO;
            end else if (pick < 55) begin
                dl_style = DL_TIGHT;
            end else begin
                dl_style = DL_FULL_RANGE;
            end
            send_batch(n_jobs, dl_style);
        end
        job_if.valid <= 1'b0;

        // drain, then let any batch without reports finish
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d batches, %0d jobs (%0d beyond a full store), %0d slot reports",
                 board.batches_done, board.jobs_taken, board.jobs_dropped, board.slots_seen);
        $display("idle mixes on both sides plus a %0d-cycle receiver hold-off", HOLD_CYCLES);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- deadline_job_sequencer.f -----
rtl/core/djs_pkg.sv
rtl/core/djs_stream_if.sv
rtl/core/djs_front.sv
rtl/core/djs_fifo.sv
rtl/core/djs_back.sv
rtl/core/deadline_job_sequencer.sv
bench/tb.sv
